// File: rtl/ujp_pkg.sv
`default_nettype none
package ujp_pkg;

  localparam int MAX_CHUNK_DEF = 2047;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [7:0] PRE0          = 8'h55;
  localparam logic [7:0] PRE1          = 8'hAA;
  localparam logic [7:0] TYPE_JOB      = 8'h21;
  localparam logic [7:0] TYPE_CMD      = 8'h51;
  localparam logic [7:0] MASK_TARGET   = 8'h14;
  localparam int         PAYLOAD_START = 6;
  localparam int         MASK_POS      = 5;
  localparam int         TARGET_LAST   = 13;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_TARGET  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  localparam logic [2:0] REJ_NONE      = 3'd0;
  localparam logic [2:0] REJ_SHORT     = 3'd1;
  localparam logic [2:0] REJ_PREAMBLE  = 3'd2;
  localparam logic [2:0] REJ_TYPE      = 3'd3;
  localparam logic [2:0] REJ_MASK      = 3'd4;
  localparam logic [2:0] REJ_TRUNCATED = 3'd5;

  // One classified result waiting for the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [63:0] target;
    logic [2:0]  code;
  } act_t;

endpackage
`default_nettype wire

// File: rtl/ujp_in_if.sv
`default_nettype none
interface ujp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface
`default_nettype wire

// File: rtl/ujp_out_if.sv
`default_nettype none
interface ujp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [63:0] target_value;
  logic [2:0]  reject_code;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_last, output target_value, output reject_code,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_last, input target_value, input reject_code,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/uart_job_command_frame_parser_core.sv
`default_nettype none
// Channel   Dir  Fields
// in_word   in   rx_byte[7:0], chunk_end
// out_word  out  result_kind[1:0], payload_byte[7:0], payload_last,
//                target_value[63:0], reject_code[2:0]
//
// One word is accepted per cycle while the queue is not full; each result
// passes from the queue into the output register once the words ahead drain.
// The front end updates the chunk state for each accepted byte; the
// four-entry queue lets the front keep accepting while out_word stalls.
// in_word.ready drops only when the queue is full. Reset (rst_n, synchronous)
// clears the chunk state, the target mask, the queue and the output valid flag.
module uart_job_command_frame_parser_core #(
  parameter int MAX_CHUNK = ujp_pkg::MAX_CHUNK_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ujp_in_if.sink    in_word,
  ujp_out_if.source out_word
);
  import ujp_pkg::*;

  logic fire, push, pop, empty, full;
  act_t act, head;

  assign in_word.ready = !full;
  assign fire          = in_word.valid && !full;

  ujp_front #(.MAX_CHUNK(MAX_CHUNK)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (in_word.rx_byte),
    .chunk_end (in_word.chunk_end),
    .push      (push),
    .act       (act)
  );

  ujp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_act (act),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  ujp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

// File: rtl/ujp_front.sv
`default_nettype none
module ujp_front #(
  parameter int MAX_CHUNK = ujp_pkg::MAX_CHUNK_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fire,
  input  wire logic [7:0]   rx_byte,
  input  wire logic         chunk_end,
  output logic              push,
  output ujp_pkg::act_t     act
);
  import ujp_pkg::*;

  localparam int PW = $clog2(MAX_CHUNK + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    type_r, type_nxt;
  logic          pre_r, pre_nxt;
  logic [7:0]    mask_r, mask_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [63:0]   asm_r, asm_nxt;
  logic          done_r, done_nxt;
  logic          emit;
  logic [2:0]    code;

  always_comb begin
    pos_nxt  = pos_r;
    type_nxt = type_r;
    pre_nxt  = pre_r;
    mask_nxt = mask_r;
    rem_nxt  = rem_r;
    asm_nxt  = asm_r;
    done_nxt = done_r;
    emit     = 1'b0;
    act      = '0;
    code     = REJ_NONE;

    if (pos_r < PW'(MAX_CHUNK)) begin
      if (pos_r == PW'(0)) begin
        pre_nxt = (rx_byte == PRE0);
      end else if (pos_r == PW'(1)) begin
        pre_nxt = pre_r && (rx_byte == PRE1);
      end else if (pos_r == PW'(2)) begin
        type_nxt = rx_byte;
      end else if (pos_r == PW'(3)) begin
        rem_nxt = (rx_byte > 8'(PAYLOAD_START)) ? rx_byte - 8'(PAYLOAD_START) : 8'd0;
      end else if (pos_r == PW'(MASK_POS)) begin
        mask_nxt = rx_byte;
      end else if (pos_r >= PW'(PAYLOAD_START)) begin
        if (pre_r && type_r == TYPE_JOB && rem_r != 8'd0) begin
          rem_nxt   = rem_r - 8'd1;
          emit      = 1'b1;
          act.kind  = KIND_PAYLOAD;
          act.data  = rx_byte;
          act.last  = (rem_r == 8'd1) || chunk_end;
        end
        if (pos_r <= PW'(TARGET_LAST)) begin
          asm_nxt = {asm_r[55:0], rx_byte};
          if (pos_r == PW'(TARGET_LAST) && pre_r && type_r == TYPE_CMD &&
              mask_r == MASK_TARGET) begin
            done_nxt   = 1'b1;
            emit       = 1'b1;
            act.kind   = KIND_TARGET;
            act.target = asm_nxt;
          end
        end
      end
      pos_nxt = pos_r + PW'(1);
    end

    // End-of-chunk checks run on the saturated chunk length.
    if (chunk_end) begin
      if (!emit) begin
        if (pos_nxt < PW'(4)) code = REJ_SHORT;
        else if (!pre_nxt) code = REJ_PREAMBLE;
        else if (type_nxt == TYPE_JOB) code = REJ_NONE;
        else if (type_nxt != TYPE_CMD) code = REJ_TYPE;
        else if (pos_nxt <= PW'(MASK_POS)) code = REJ_TRUNCATED;
        else if (mask_nxt != MASK_TARGET) code = REJ_MASK;
        else if (!done_nxt) code = REJ_TRUNCATED;
        else code = REJ_NONE;
        if (code != REJ_NONE) begin
          emit     = 1'b1;
          act.kind = KIND_REJECT;
          act.code = code;
        end
      end
      pos_nxt  = '0;
      type_nxt = '0;
      pre_nxt  = 1'b0;
      mask_nxt = '0;
      rem_nxt  = '0;
      asm_nxt  = '0;
      done_nxt = 1'b0;
    end

    push = fire && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      type_r <= '0;
      pre_r  <= 1'b0;
      mask_r <= '0;
      rem_r  <= '0;
      asm_r  <= '0;
      done_r <= 1'b0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      pre_r  <= pre_nxt;
      mask_r <= mask_nxt;
      rem_r  <= rem_nxt;
      asm_r  <= asm_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ujp_fifo.sv
`default_nettype none
module ujp_fifo #(
  parameter int DEPTH = ujp_pkg::FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ujp_pkg::act_t push_act,
  input  wire logic          pop,
  output ujp_pkg::act_t      head,
  output logic               empty,
  output logic               full
);
  import ujp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  act_t          slot_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == CW'(0));
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      if (pop)  rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/ujp_back.sv
`default_nettype none
module ujp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ujp_pkg::act_t head,
  input  wire logic          empty,
  output logic               pop,
  ujp_out_if.source          out_word
);
  import ujp_pkg::*;

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic [63:0] tgt_r;
  logic [2:0]  code_r;
  logic [63:0] target_mask_r, target_mask_nxt;

  // Take the next word whenever the output register is free or being drained.
  assign pop = !empty && (!valid_r || out_word.ready);

  always_comb begin
    target_mask_nxt = target_mask_r;
    if (head.kind == KIND_TARGET) target_mask_nxt = head.target;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      target_mask_r <= '0;
    end else begin
      if (pop) begin
        valid_r       <= 1'b1;
        target_mask_r <= target_mask_nxt;
      end else if (out_word.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head.kind;
      data_r <= head.data;
      last_r <= head.last;
      code_r <= head.code;
      tgt_r  <= (head.kind == KIND_TARGET) ? target_mask_nxt : 64'd0;
    end
  end

  assign out_word.valid        = valid_r;
  assign out_word.result_kind  = kind_r;
  assign out_word.payload_byte = data_r;
  assign out_word.payload_last = last_r;
  assign out_word.target_value = tgt_r;
  assign out_word.reject_code  = code_r;

endmodule
`default_nettype wire
